@@ rtl/qoe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qoe_pkg;

	// Component width of both quaternions and of the error outputs
	localparam int CW = 16;
	localparam int IN_W = 8 * CW;
	localparam int OUT_W = 3 * CW;

	// Default number of CORDIC iterations
	localparam int CORDIC_STEPS_DEF = 16;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// Datapath widths of the back end
	localparam int PRW = 2 * CW;          // one product of scaled components
	localparam int DSW = PRW + 2;         // sum of four products, signed
	localparam int DMW = DSW - 1;         // magnitude of that sum
	localparam int DMSB = 29;             // target top bit of the scaled difference
	localparam int VMW = DMSB + 1;        // scaled difference magnitudes
	localparam int SQW = 2 * VMW;         // one square
	localparam int RSW = 64;              // root remainder and partial root
	localparam int SQRT_STEPS = 32;       // one result bit per step
	localparam int RTW = 32;              // square root result
	localparam int SMALL_K = 1000000;     // small-angle ratio
	localparam int SMW = RTW + 20;        // root times small-angle ratio
	localparam int CXW = 36;              // CORDIC x and y
	localparam int ZW = 28;               // CORDIC angle, Q.24 radians
	localparam int ZMW = ZW - 1;          // angle magnitude
	localparam int DEN_SH = 26 - CW;      // scale from Q.24 angle to Q1.(CW-2)
	localparam int DENW = RTW + DEN_SH;   // divisor
	localparam int NUMW = 58;             // dividend with rounding term
	localparam int QTW = 18;              // quotient bits
	localparam int DIVW = DENW + QTW;     // widest shifted divisor

	typedef logic signed [CW-1:0] comp_t;
	typedef comp_t [3:0] quat_t;

	// One classified and scaled quaternion pair, front to back
	typedef struct packed {
		logic  invalid;
		quat_t t;
		quat_t a;
	} front_item_t;

	// atan(2^-i) in Q.24 radians, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		case (i)
			0:  return ZW'(13176795);
			1:  return ZW'(7778716);
			2:  return ZW'(4110060);
			3:  return ZW'(2086331);
			4:  return ZW'(1047214);
			5:  return ZW'(524117);
			6:  return ZW'(262123);
			7:  return ZW'(131069);
			8:  return ZW'(65536);
			9:  return ZW'(32768);
			10: return ZW'(16384);
			11: return ZW'(8192);
			12: return ZW'(4096);
			13: return ZW'(2048);
			14: return ZW'(1024);
			15: return ZW'(512);
			16: return ZW'(256);
			17: return ZW'(128);
			18: return ZW'(64);
			19: return ZW'(32);
			20: return ZW'(16);
			21: return ZW'(8);
			22: return ZW'(4);
			23: return ZW'(2);
			24: return ZW'(1);
			default: return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ rtl/qoe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qoe_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [qoe_pkg::IN_W-1:0]  s_tdata,
	output qoe_pkg::front_item_t      item,
	output logic                      item_valid,
	input  logic                      item_ready
);

	logic                     v_s1;
	logic [qoe_pkg::IN_W-1:0] raw_s1;
	qoe_pkg::quat_t           t_raw, a_raw;

	// Scale so the largest magnitude has its top bit at CW-2
	function automatic qoe_pkg::quat_t scale_quat(input qoe_pkg::quat_t q);
		logic [qoe_pkg::CW-1:0]         m [4];
		logic [qoe_pkg::CW-1:0]         acc;
		logic [$clog2(qoe_pkg::CW)-1:0] pos;
		logic [$clog2(qoe_pkg::CW):0]   sh;
		logic [qoe_pkg::CW-1:0]         s;
		qoe_pkg::quat_t                 r;
		acc = '0;
		pos = '0;
		for (int i = 0; i < 4; i++) begin
			m[i] = q[i][qoe_pkg::CW-1] ? qoe_pkg::CW'(~q[i] + 1'b1) : qoe_pkg::CW'(q[i]);
			acc = acc | m[i];
		end
		for (int b = 0; b < qoe_pkg::CW; b++) begin
			if (acc[b]) begin
				pos = ($clog2(qoe_pkg::CW))'(b);
			end
		end
		sh = ($clog2(qoe_pkg::CW)+1)'(qoe_pkg::CW - 2) - ($clog2(qoe_pkg::CW)+1)'(pos);
		for (int i = 0; i < 4; i++) begin
			if (pos == ($clog2(qoe_pkg::CW))'(qoe_pkg::CW - 1)) begin
				s = m[i] >> 1;
			end else begin
				s = m[i] << sh;
			end
			r[i] = q[i][qoe_pkg::CW-1] ? qoe_pkg::comp_t'(-$signed(s)) : qoe_pkg::comp_t'(s);
		end
		return r;
	endfunction

	// Hold the raw pair until the queue takes it
	assign s_tready = !v_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata;
		end
	end

	// Unpack, classify the zero quaternion, scale both
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			t_raw[k] = raw_s1[qoe_pkg::CW*k +: qoe_pkg::CW];
			a_raw[k] = raw_s1[qoe_pkg::CW*(k+4) +: qoe_pkg::CW];
		end
		item.invalid = (t_raw == '0) || (a_raw == '0);
		item.t = scale_quat(t_raw);
		item.a = scale_quat(a_raw);
	end

	assign item_valid = v_s1;

endmodule

`default_nettype wire

@@ rtl/qoe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qoe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qoe_pkg::front_item_t in_item,
	input  logic                 in_valid,
	output logic                 in_ready,
	output qoe_pkg::front_item_t out_item,
	output logic                 out_valid,
	input  logic                 out_ready
);

	qoe_pkg::front_item_t       mem_q [qoe_pkg::QDEPTH];
	logic [qoe_pkg::QAW-1:0]    wr_q, rd_q;
	logic [qoe_pkg::QAW:0]      cnt_q;
	logic                       push, pop;

	assign in_ready  = cnt_q != (qoe_pkg::QAW+1)'(qoe_pkg::QDEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_q];

	// Store an entry on each push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/qoe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qoe_back #(
	parameter int CORDIC_STEPS = qoe_pkg::CORDIC_STEPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qoe_pkg::front_item_t      item,
	input  logic                      item_valid,
	output logic                      item_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [qoe_pkg::OUT_W-1:0] out_data,
	output logic                      out_status
);

	localparam int CW    = qoe_pkg::CW;
	localparam int PRW   = qoe_pkg::PRW;
	localparam int DSW   = qoe_pkg::DSW;
	localparam int DMW   = qoe_pkg::DMW;
	localparam int DMSB  = qoe_pkg::DMSB;
	localparam int VMW   = qoe_pkg::VMW;
	localparam int SQW   = qoe_pkg::SQW;
	localparam int RSW   = qoe_pkg::RSW;
	localparam int NSQ   = qoe_pkg::SQRT_STEPS;
	localparam int RTW   = qoe_pkg::RTW;
	localparam int SMW   = qoe_pkg::SMW;
	localparam int CXW   = qoe_pkg::CXW;
	localparam int ZW    = qoe_pkg::ZW;
	localparam int ZMW   = qoe_pkg::ZMW;
	localparam int DENW  = qoe_pkg::DENW;
	localparam int NUMW  = qoe_pkg::NUMW;
	localparam int QTW   = qoe_pkg::QTW;
	localparam int DIVW  = qoe_pkg::DIVW;
	localparam int PW    = $clog2(DMW + 1);
	localparam int LIM   = 1 << (CW - 1);

	typedef struct packed {
		logic                 inv;
		logic [VMW-1:0]       dw;
		logic [2:0][VMW-1:0]  vm;
		logic [2:0]           vneg;
	} sq_carry_t;

	typedef struct packed {
		logic                 inv;
		logic                 small_ang;
		logic [RTW-1:0]       nv;
		logic [2:0][VMW-1:0]  vm;
		logic [2:0]           vneg;
	} cd_carry_t;

	typedef struct packed {
		logic                 inv;
		logic                 small_ang;
		logic [2:0]           neg;
		logic [DENW-1:0]      den;
	} dv_carry_t;

	typedef struct packed {
		logic [RSW-1:0] rem;
		logic [RSW-1:0] rt;
	} rs_t;

	typedef struct packed {
		logic [DIVW-1:0] rem;
		logic [QTW-1:0]  q;
	} dq_t;

	// One digit of the integer square root
	function automatic rs_t sqrt_step(input rs_t s, input logic [RSW-1:0] b);
		logic [RSW-1:0] c;
		rs_t            o;
		c = s.rt + b;
		if (s.rem >= c) begin
			o.rem = s.rem - c;
			o.rt  = (s.rt >> 1) + b;
		end else begin
			o.rem = s.rem;
			o.rt  = s.rt >> 1;
		end
		return o;
	endfunction

	// One quotient bit of the restoring divider
	function automatic dq_t div_step(input dq_t s, input logic [DENW-1:0] den, input int b);
		logic [DIVW-1:0] dv;
		dq_t             o;
		dv = DIVW'(den) << b;
		o  = s;
		if (s.rem >= dv) begin
			o.rem  = s.rem - dv;
			o.q[b] = 1'b1;
		end
		return o;
	endfunction

	// Clamp a sign and magnitude to the signed output range
	function automatic logic [CW-1:0] sat_out(input logic neg, input logic [QTW-1:0] q);
		logic [QTW-1:0] m;
		if (neg) begin
			m = (q > QTW'(LIM)) ? QTW'(LIM) : q;
			return CW'(QTW'(0) - m);
		end
		m = (q > QTW'(LIM - 1)) ? QTW'(LIM - 1) : q;
		return CW'(m);
	endfunction

	logic adv;

	logic                  v_s1, inv_s1;
	logic signed [PRW-1:0] prod_s1 [16];
	logic                  v_s2, inv_s2;
	logic signed [DSW-1:0] d_s2 [4];
	logic                  v_s3, inv_s3;
	logic [DMW-1:0]        dm_s3 [4];
	logic [3:0]            dn_s3;
	logic [PW-1:0]         pos_s3;
	logic                  v_s4;
	sq_carry_t             c_s4;
	logic                  v_s5;
	sq_carry_t             c_s5;
	logic [SQW-1:0]        sq_s5 [4];
	logic                  v_s6;
	sq_carry_t             c_s6;
	logic [SQW:0]          ab_s6, cw_s6;
	logic [SQW-1:0]        sz_s6;

	logic                  sq_v_sq [NSQ+1];
	sq_carry_t             sq_c_sq [NSQ+1];
	rs_t                   rv_sq   [NSQ+1];
	rs_t                   rd_sq   [NSQ+1];

	logic                  v_s8;
	sq_carry_t             c_s8;
	logic [SMW-1:0]        smul_s8;
	logic [RTW-1:0]        nv_s8, nd_s8;

	logic                  cd_v_cd [CORDIC_STEPS+1];
	cd_carry_t             cd_c_cd [CORDIC_STEPS+1];
	logic signed [CXW-1:0] cx_cd   [CORDIC_STEPS+1];
	logic signed [CXW-1:0] cy_cd   [CORDIC_STEPS+1];
	logic signed [ZW-1:0]  cz_cd   [CORDIC_STEPS+1];

	logic                  v_s10;
	dv_carry_t             c_s10;
	logic [NUMW-1:0]       num_s10 [3];

	logic                  dv_v_dv [QTW+1];
	dv_carry_t             dv_c_dv [QTW+1];
	dq_t [2:0]             dq_dv   [QTW+1];

	logic                  out_valid_q;
	logic [CW-1:0]         err_q [3];
	logic                  status_q;

	logic [DMW-1:0]        dm_c [4];
	logic [PW-1:0]         pos_c;
	logic [VMW-1:0]        sc_c [4];
	logic [DMW+DMSB-1:0]   wide_c;
	logic                  flip_c;
	logic [ZMW-1:0]        zm_c;
	logic                  zn_c;

	// Stall the whole back end while a result waits
	assign adv        = !out_valid_q || out_ready;
	assign item_ready = adv;

	// Advance the valid chain of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			sq_v_sq[0]  <= 1'b0;
			v_s8        <= 1'b0;
			cd_v_cd[0]  <= 1'b0;
			v_s10       <= 1'b0;
			dv_v_dv[0]  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= item_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			sq_v_sq[0]  <= v_s6;
			v_s8        <= sq_v_sq[NSQ];
			cd_v_cd[0]  <= v_s8;
			v_s10       <= cd_v_cd[CORDIC_STEPS];
			dv_v_dv[0]  <= v_s10;
			out_valid_q <= dv_v_dv[QTW];
		end
	end

	// Magnitudes and top bit of the difference
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < 4; i++) begin
			dm_c[i] = d_s2[i][DSW-1] ? DMW'(-d_s2[i]) : DMW'(d_s2[i]);
		end
		for (int b = 0; b < DMW; b++) begin
			if (dm_c[0][b] || dm_c[1][b] || dm_c[2][b] || dm_c[3][b]) begin
				pos_c = PW'(b);
			end
		end
	end

	// Shift the difference to its target range
	always_comb begin
		wide_c = '0;
		for (int i = 0; i < 4; i++) begin
			if (pos_s3 > PW'(DMSB)) begin
				sc_c[i] = VMW'(dm_s3[i] >> (pos_s3 - PW'(DMSB)));
			end else begin
				wide_c  = (DMW+DMSB)'(dm_s3[i]) << (PW'(DMSB) - pos_s3);
				sc_c[i] = wide_c[VMW-1:0];
			end
		end
		flip_c = dn_s3[0] && (sc_c[0] != '0);
	end

	// Angle sign and magnitude after the CORDIC
	assign zn_c = cz_cd[CORDIC_STEPS][ZW-1];
	assign zm_c = zn_c ? ZMW'(-cz_cd[CORDIC_STEPS]) : ZMW'(cz_cd[CORDIC_STEPS]);

	// Fixed stages: product, sum, scale, squares, sums, ratio, divide setup
	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s1 <= item.invalid;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[4*i+j] <= item.t[i] * item.a[j];
				end
			end

			inv_s2  <= inv_s1;
			d_s2[0] <= DSW'(prod_s1[0]) + DSW'(prod_s1[5]) + DSW'(prod_s1[10])
				+ DSW'(prod_s1[15]);
			d_s2[1] <= DSW'(prod_s1[4]) - DSW'(prod_s1[1]) - DSW'(prod_s1[11])
				+ DSW'(prod_s1[14]);
			d_s2[2] <= DSW'(prod_s1[7]) - DSW'(prod_s1[2]) + DSW'(prod_s1[8])
				- DSW'(prod_s1[13]);
			d_s2[3] <= DSW'(prod_s1[9]) - DSW'(prod_s1[3]) - DSW'(prod_s1[6])
				+ DSW'(prod_s1[12]);

			inv_s3 <= inv_s2;
			pos_s3 <= pos_c;
			for (int i = 0; i < 4; i++) begin
				dm_s3[i] <= dm_c[i];
				dn_s3[i] <= d_s2[i][DSW-1];
			end

			c_s4.inv <= inv_s3;
			c_s4.dw  <= sc_c[0];
			for (int i = 0; i < 3; i++) begin
				c_s4.vm[i]   <= sc_c[i+1];
				c_s4.vneg[i] <= dn_s3[i+1] ^ flip_c;
			end

			c_s5     <= c_s4;
			sq_s5[0] <= SQW'(c_s4.dw) * SQW'(c_s4.dw);
			for (int i = 0; i < 3; i++) begin
				sq_s5[i+1] <= SQW'(c_s4.vm[i]) * SQW'(c_s4.vm[i]);
			end

			c_s6  <= c_s5;
			ab_s6 <= (SQW+1)'(sq_s5[1]) + (SQW+1)'(sq_s5[2]);
			cw_s6 <= (SQW+1)'(sq_s5[3]) + (SQW+1)'(sq_s5[0]);
			sz_s6 <= sq_s5[3];

			sq_c_sq[0]    <= c_s6;
			rv_sq[0].rem  <= RSW'(ab_s6) + RSW'(sz_s6);
			rv_sq[0].rt   <= '0;
			rd_sq[0].rem  <= RSW'(ab_s6) + RSW'(cw_s6);
			rd_sq[0].rt   <= '0;

			c_s8    <= sq_c_sq[NSQ];
			nv_s8   <= rv_sq[NSQ].rt[RTW-1:0];
			nd_s8   <= rd_sq[NSQ].rt[RTW-1:0];
			smul_s8 <= SMW'(rv_sq[NSQ].rt[RTW-1:0]) * SMW'(qoe_pkg::SMALL_K);

			cd_c_cd[0].inv       <= c_s8.inv;
			cd_c_cd[0].small_ang <= smul_s8 < SMW'(nd_s8);
			cd_c_cd[0].nv        <= nv_s8;
			cd_c_cd[0].vm        <= c_s8.vm;
			cd_c_cd[0].vneg      <= c_s8.vneg;
			cx_cd[0]             <= CXW'(c_s8.dw);
			cy_cd[0]             <= CXW'(nv_s8);
			cz_cd[0]             <= '0;

			c_s10.inv       <= cd_c_cd[CORDIC_STEPS].inv;
			c_s10.small_ang <= cd_c_cd[CORDIC_STEPS].small_ang;
			c_s10.den       <= DENW'(cd_c_cd[CORDIC_STEPS].nv) << qoe_pkg::DEN_SH;
			for (int i = 0; i < 3; i++) begin
				c_s10.neg[i] <= zn_c ^ cd_c_cd[CORDIC_STEPS].vneg[i];
				num_s10[i]   <= NUMW'(zm_c) * NUMW'(cd_c_cd[CORDIC_STEPS].vm[i]);
			end

			dv_c_dv[0] <= c_s10;
			for (int i = 0; i < 3; i++) begin
				dq_dv[0][i].rem <= DIVW'(num_s10[i]) + DIVW'(c_s10.den >> 1);
				dq_dv[0][i].q   <= '0;
			end
		end
	end

	// Root stages: one result bit of both roots per stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam logic [RSW-1:0] BIT = RSW'(1) << (2 * (NSQ - 1 - k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_sq[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v_sq[k+1] <= sq_v_sq[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_c_sq[k+1] <= sq_c_sq[k];
				rv_sq[k+1]   <= sqrt_step(rv_sq[k], BIT);
				rd_sq[k+1]   <= sqrt_step(rd_sq[k], BIT);
			end
		end
	end

	// CORDIC stages: rotate toward the x axis, accumulate the angle
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CXW-1:0] xs, ys;

		assign xs = cx_cd[i] >>> i;
		assign ys = cy_cd[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_v_cd[i+1] <= 1'b0;
			end else if (adv) begin
				cd_v_cd[i+1] <= cd_v_cd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cd_c_cd[i+1] <= cd_c_cd[i];
				if (!cy_cd[i][CXW-1]) begin
					cx_cd[i+1] <= cx_cd[i] + ys;
					cy_cd[i+1] <= cy_cd[i] - xs;
					cz_cd[i+1] <= cz_cd[i] + qoe_pkg::atan_q24(i);
				end else begin
					cx_cd[i+1] <= cx_cd[i] - ys;
					cy_cd[i+1] <= cy_cd[i] + xs;
					cz_cd[i+1] <= cz_cd[i] - qoe_pkg::atan_q24(i);
				end
			end
		end
	end

	// Divider stages: one quotient bit of all three lanes per stage
	for (genvar j = 0; j < QTW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_dv[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_dv[j+1] <= dv_v_dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_c_dv[j+1] <= dv_c_dv[j];
				for (int l = 0; l < 3; l++) begin
					dq_dv[j+1][l] <= div_step(dq_dv[j][l], dv_c_dv[j].den, QTW - 1 - j);
				end
			end
		end
	end

	// Saturate the result, or zero it for an invalid or small-angle pair, and hold it
	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= dv_c_dv[QTW].inv;
			for (int l = 0; l < 3; l++) begin
				if (dv_c_dv[QTW].inv || dv_c_dv[QTW].small_ang) begin
					err_q[l] <= '0;
				end else begin
					err_q[l] <= sat_out(dv_c_dv[QTW].neg[l] && (dq_dv[QTW][l].q != '0),
						dq_dv[QTW][l].q);
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = {err_q[2], err_q[1], err_q[0]};
	assign out_status = status_q;

endmodule

`default_nettype wire

@@ rtl/quaternion_orientation_error.sv @@
// Throughput: one quaternion pair per cycle; the front, queue and back pipeline each
// take a new transaction every cycle while the output side keeps up.
// The back pipeline advances as one unit and holds while a result waits at the output.
// Reset: arst_n clears all valid state asynchronously; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_orientation_error #(
	parameter int CORDIC_STEPS = qoe_pkg::CORDIC_STEPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// target_w, target_x, target_y, target_z, actual_w, actual_x, actual_y, actual_z
	input  logic [qoe_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// err_x, err_y, err_z
	output logic [qoe_pkg::OUT_W-1:0] m_tdata,
	// status
	output logic                      m_tuser
);

	qoe_pkg::front_item_t fr_item, q_item;
	logic                 fr_valid, fr_ready;
	logic                 q_valid, q_ready;

	// Accept and classify pairs
	qoe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item       (fr_item),
		.item_valid (fr_valid),
		.item_ready (fr_ready)
	);

	// Decouple front from back
	qoe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (fr_item),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.out_item  (q_item),
		.out_valid (q_valid),
		.out_ready (q_ready)
	);

	// Compute the rotation-vector error
	qoe_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int LATENCY = 63 + qoe_pkg::CORDIC_STEPS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 500;

	typedef struct packed {
		logic        invalid;
		logic [15:0] ex;
		logic [15:0] ey;
		logic [15:0] ez;
	} orient_err_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [qoe_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [qoe_pkg::OUT_W-1:0] m_tdata;
	logic m_tuser;

	logic [qoe_pkg::IN_W-1:0] pending_pairs[$];
	orient_err_t expected_errs[$];
	int fail_count = 0;
	int results_seen = 0;
	int invalid_seen = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit hold_phase_done = 1'b0;
	bit stim_done = 1'b0;

	quaternion_orientation_error uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function automatic longint unsigned mag64(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// floor division by a power of two
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// scale so the largest magnitude lands in [2^(b-1), 2^b); truncate magnitudes
	function automatic void norm_block(ref longint c[4], input int b);
		longint unsigned m;
		longint unsigned a;
		int sh;
		m = 0;
		sh = 0;
		foreach (c[i]) if (mag64(c[i]) > m) m = mag64(c[i]);
		if (m == 0) return;
		while (m >= (64'd1 << b)) begin m >>= 1; sh--; end
		while (m < (64'd1 << (b - 1))) begin m <<= 1; sh++; end
		foreach (c[i]) begin
			a = mag64(c[i]);
			a = sh >= 0 ? a << sh : a >> (-sh);
			c[i] = c[i] < 0 ? -longint'(a) : longint'(a);
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] clamp_err(bit neg, longint unsigned m);
		if (neg) begin
			if (m > 32768) m = 32768;
			return 16'(-longint'(m));
		end
		if (m > 32767) m = 32767;
		return 16'(m);
	endfunction

	function automatic orient_err_t predict_error(logic [qoe_pkg::IN_W-1:0] pair);
		orient_err_t r;
		longint t[4], a[4], d[4];
		longint x, y, z, xs, ys;
		longint unsigned nv2, nv, nd, den, num;
		logic [15:0] e[3];
		bit tz, az;
		r = '0;
		tz = 1;
		az = 1;
		for (int i = 0; i < 4; i++) begin
			t[i] = longint'($signed(pair[16*i +: 16]));
			a[i] = longint'($signed(pair[16*(i+4) +: 16]));
			if (t[i] != 0) tz = 0;
			if (a[i] != 0) az = 0;
		end
		if (tz || az) begin
			r.invalid = 1'b1;
			return r;
		end
		norm_block(t, 15);
		norm_block(a, 15);
		d[0] = t[0]*a[0] + t[1]*a[1] + t[2]*a[2] + t[3]*a[3];
		d[1] = -t[0]*a[1] + t[1]*a[0] - t[2]*a[3] + t[3]*a[2];
		d[2] = -t[0]*a[2] + t[1]*a[3] + t[2]*a[0] - t[3]*a[1];
		d[3] = -t[0]*a[3] - t[1]*a[2] + t[2]*a[1] + t[3]*a[0];
		norm_block(d, 30);
		if (d[0] < 0) foreach (d[i]) d[i] = -d[i];
		nv2 = d[1]*d[1] + d[2]*d[2] + d[3]*d[3];
		nv = int_sqrt(nv2);
		nd = int_sqrt(nv2 + d[0]*d[0]);
		if (nv * 1000000 < nd) return r;
		// vectoring rotations toward the x axis
		x = d[0];
		y = longint'(nv);
		z = 0;
		for (int i = 0; i < qoe_pkg::CORDIC_STEPS_DEF; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(qoe_pkg::atan_q24(i));
			end else begin
				x -= ys; y += xs; z -= longint'(qoe_pkg::atan_q24(i));
			end
		end
		den = nv << 10;
		for (int i = 0; i < 3; i++) begin
			num = mag64(z) * mag64(d[1+i]);
			num = (num + den / 2) / den;
			e[i] = clamp_err(((z < 0) != (d[1+i] < 0)) && num != 0, num);
		end
		r.ex = e[0];
		r.ey = e[1];
		r.ez = e[2];
		return r;
	endfunction

	function automatic logic [qoe_pkg::IN_W-1:0] pack_pair(logic [15:0] tq[4],
		logic [15:0] aq[4]);
		logic [qoe_pkg::IN_W-1:0] p;
		for (int i = 0; i < 4; i++) begin
			p[16*i +: 16] = tq[i];
			p[16*(i+4) +: 16] = aq[i];
		end
		return p;
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 6)) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 29) == 0) return $urandom_range(20, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// fill the queue of quaternion pairs
	initial begin
		logic [15:0] tq[4], aq[4];
		tq = '{16'sd16384, 0, 0, 0};
		// identity against identity, and against each axis flip
		pending_pairs.push_back(pack_pair(tq, tq));
		for (int k = 1; k < 4; k++) begin
			aq = '{0, 0, 0, 0};
			aq[k] = 16'sd16384;
			pending_pairs.push_back(pack_pair(tq, aq));
		end
		// zero-norm target, actual, and both
		aq = '{0, 0, 0, 0};
		pending_pairs.push_back(pack_pair(tq, aq));
		pending_pairs.push_back(pack_pair(aq, tq));
		pending_pairs.push_back(pack_pair(aq, aq));
		// extreme components
		tq = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
		aq = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
		pending_pairs.push_back(pack_pair(tq, aq));
		pending_pairs.push_back(pack_pair(aq, tq));
		tq = '{16'h8000, 16'h7fff, 0, 16'h8000};
		pending_pairs.push_back(pack_pair(tq, aq));
		// tiny components; the first pair gives a negative scalar of the difference
		tq = '{1, 0, 0, 0};
		aq = '{16'hffff, 0, 0, 0};
		pending_pairs.push_back(pack_pair(tq, aq));
		aq = '{0, 0, 16'hffff, 0};
		pending_pairs.push_back(pack_pair(tq, aq));
		// small angle: nearly equal quaternions
		tq = '{16'sd16384, 16'sd1, 0, 0};
		aq = '{16'sd16384, 0, 0, 0};
		pending_pairs.push_back(pack_pair(tq, aq));
		tq = '{16'h7fff, 16'h0001, 0, 0};
		aq = '{16'h7fff, 0, 0, 0};
		pending_pairs.push_back(pack_pair(tq, aq));
		// near pi rotations
		tq = '{16'sd1, 16'sd16384, 0, 0};
		aq = '{16'sd16384, 0, 0, 0};
		pending_pairs.push_back(pack_pair(tq, aq));
		tq = '{16'hffff, 0, 16'sd16384, 16'sd16384};
		pending_pairs.push_back(pack_pair(tq, aq));
		for (int n = 0; n < N_RANDOM; n++) begin
			foreach (tq[i]) tq[i] = rand_comp();
			if ($urandom_range(0, 3) == 0) begin
				// close pair: actual is target plus a small wobble
				foreach (aq[i]) aq[i] = tq[i] + 16'(int'($urandom_range(0, 64)) - 32);
			end else begin
				foreach (aq[i]) aq[i] = rand_comp();
			end
			pending_pairs.push_back(pack_pair(tq, aq));
		end
		stim_done = 1'b1;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: offer pairs with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_errs.push_back(predict_error(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					s_tdata <= pending_pairs.pop_front();
					s_tvalid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stalls; one long hold-off partway through
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_phase_done && stim_done && pending_pairs.size() < N_RANDOM - 100) begin
				hold_phase_done <= 1'b1;
				stall_left <= 300;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		orient_err_t want;
		int bad;
		bad = 0;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (m_tuser) invalid_seen <= invalid_seen + 1;
			if (expected_errs.size() == 0) begin
				$error("unexpected result transaction %h/%b", m_tdata, m_tuser);
				bad++;
			end else begin
				want = expected_errs.pop_front();
				if (m_tdata[15:0] !== want.ex) begin
					$error("err_x expected %0d got %0d", $signed(want.ex), $signed(m_tdata[15:0]));
					bad++;
				end
				if (m_tdata[31:16] !== want.ey) begin
					$error("err_y expected %0d got %0d", $signed(want.ey),
						$signed(m_tdata[31:16]));
					bad++;
				end
				if (m_tdata[47:32] !== want.ez) begin
					$error("err_z expected %0d got %0d", $signed(want.ez),
						$signed(m_tdata[47:32]));
					bad++;
				end
				if (m_tuser !== want.invalid) begin
					$error("status expected %0b got %0b", want.invalid, m_tuser);
					bad++;
				end
			end
			fail_count <= fail_count + bad;
		end
	end

	// watchdog: count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_errs.size());
			$display("simulation failed");
			$finish;
		end
	end

	// wait for the drain, then report
	initial begin
		wait (arst_n && stim_done);
		wait (pending_pairs.size() == 0 && !s_tvalid);
		wait (expected_errs.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		$display("checked %0d orientation errors, %0d with a zero-norm quaternion,",
			results_seen, invalid_seen);
		$display("including directed axis, extreme and small-angle pairs plus a long output stall");
		if (fail_count == 0 && expected_errs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
